// ===== rtl/ssis_pkg.sv =====
`default_nettype none
package ssis_pkg;

    localparam int VALUE_W      = 32;
    localparam int COUNT_OUT_W  = 5;
    localparam int CAPACITY_DEF = 16;

    typedef logic signed [VALUE_W-1:0] t_value;

    typedef enum logic [0:0] {
        CMD_INSERT = 1'b0,
        CMD_QUERY  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_DUPLICATE = 2'd1,
        ST_FULL      = 2'd2,
        ST_QUERY     = 2'd3
    } t_status;

    typedef struct packed {
        logic   insert_en;
        t_value key;
    } t_cell_ctrl;

endpackage
`default_nettype wire

// ===== rtl/sorted_set_insert_search.sv =====
// Sorted set of up to CAPACITY distinct signed 32-bit values held in a row of
// cells, ascending from cell 0. Each word on the slave side is an insert
// (tuser 0) or a query (tuser 1) of the value in tdata. All cells compare the
// key at once and, on an insert, shift larger values one cell up and drop the
// key into the gap, so one word is taken every cycle while the master side
// keeps up. Its result appears on the master side the cycle after acceptance
// in a single output register; while a result waits there the slave side is
// held off, and the next word enters in the cycle the waiting result is
// taken. Duplicates are ignored, inserts into a full set are dropped, and
// every result carries the count after the word (low five bits).
`default_nettype none
module sorted_set_insert_search #(
    parameter int CAPACITY = ssis_pkg::CAPACITY_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,   // value
    input  wire logic [0:0]  i_s_axis_tuser,   // cmd
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [7:0]       o_m_axis_tdata,   // count, zero pad
    output logic [2:0]       o_m_axis_tuser    // found, status
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]                          r_count;
    logic [CW-1:0]                          n_count;
    logic                                   r_m_valid;
    logic                                   r_found;
    ssis_pkg::t_status                      r_status;
    ssis_pkg::t_status                      n_status;
    logic [ssis_pkg::COUNT_OUT_W-1:0]       r_count_out;
    logic [CW+ssis_pkg::COUNT_OUT_W-1:0]    count_ext;

    logic                                   accept;
    logic                                   is_insert;
    logic                                   full;
    logic                                   found;
    ssis_pkg::t_cell_ctrl                   ctrl;

    logic                                   after_v [CAPACITY];
    logic [CAPACITY-1:0]                    match_v;
    ssis_pkg::t_value                       value_v [CAPACITY];

    assign o_s_axis_tready = !r_m_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign is_insert       = (i_s_axis_tuser == ssis_pkg::CMD_INSERT);
    assign full            = (r_count >= CW'(CAPACITY));
    assign found           = |match_v;

    assign ctrl.key       = $signed(i_s_axis_tdata);
    assign ctrl.insert_en = accept && is_insert && !found && !full;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic left_after;
        ssis_pkg::t_value left_value;
        if (g == 0) begin : g_first
            assign left_after = 1'b0;
            assign left_value = ctrl.key;
        end else begin : g_rest
            assign left_after = after_v[g-1];
            assign left_value = value_v[g-1];
        end
        ssis_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (ctrl),
            .i_occ        (CW'(g) < r_count),
            .i_left_after (left_after),
            .i_left_value (left_value),
            .o_after      (after_v[g]),
            .o_match      (match_v[g]),
            .o_value      (value_v[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (!is_insert) begin
            n_status = ssis_pkg::ST_QUERY;
        end else if (found) begin
            n_status = ssis_pkg::ST_DUPLICATE;
        end else if (full) begin
            n_status = ssis_pkg::ST_FULL;
        end else begin
            n_status = ssis_pkg::ST_INSERTED;
            n_count  = r_count + CW'(1);
        end
    end

    assign count_ext = (CW + ssis_pkg::COUNT_OUT_W)'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= n_count;
            end
            if (accept) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_found     <= found;
            r_status    <= n_status;
            r_count_out <= count_ext[ssis_pkg::COUNT_OUT_W-1:0];
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tuser  = {r_status, r_found};
    assign o_m_axis_tdata  = {(8 - ssis_pkg::COUNT_OUT_W)'(0), r_count_out};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("count above capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.insert_en |=> r_count == $past(r_count) + CW'(1))
        else $error("insert did not grow count");

    a_query_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !is_insert) |=> $stable(r_count))
        else $error("query changed count");

    a_dup_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_insert && found) |=>
            (r_status == ssis_pkg::ST_DUPLICATE) && r_found && $stable(r_count))
        else $error("duplicate insert mishandled");

    a_result_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_count_out == ssis_pkg::COUNT_OUT_W'(r_count))
        else $error("reported count mismatch");

endmodule
`default_nettype wire

// ===== rtl/ssis_cell.sv =====
`default_nettype none
module ssis_cell (
    input  wire logic                i_clk,
    input  wire ssis_pkg::t_cell_ctrl i_ctrl,
    input  wire logic                i_occ,
    input  wire logic                i_left_after,
    input  wire ssis_pkg::t_value    i_left_value,
    output logic                     o_after,
    output logic                     o_match,
    output ssis_pkg::t_value         o_value
);

    ssis_pkg::t_value r_value;

    // cell is past the insert point when empty or holding a larger value
    assign o_after = !i_occ || (r_value > i_ctrl.key);
    assign o_match = i_occ && (r_value == i_ctrl.key);
    assign o_value = r_value;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.insert_en) begin
            if (i_left_after) begin
                r_value <= i_left_value;
            end else if (o_after) begin
                r_value <= i_ctrl.key;
            end
        end
    end

endmodule
`default_nettype wire
